### hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min tracking stack: word layouts of the
// operation and result channels, operation kinds and error codes.
// ----------------------------------------------------------------------------
package mts_pkg;

  // default number of entries
  localparam int STACK_DEPTH_DEFAULT = 1024;

  // field widths
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  // operation kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // error codes
  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  // operation word
  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    err_t                     error_code;
  } out_word_t;

endpackage

### hw/rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO of signed 32-bit values that reports the smallest held value
// after every push or pop.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               word
//  in_      input      in_valid / in_ready     mts_pkg::in_word_t
//  out_     output     out_valid / out_ready   mts_pkg::out_word_t
//
//  A push, an error or a pop that empties the stack is answered from its
//  accept cycle; a pop that leaves one or more entries goes through ST_READ,
//  whose entry store read brings the new top entry into the top registers.
//  Reset clears the entry count, the state and the result valid flag; the stores need no clearing pass.
//  A new word is taken when no fetch is pending and the result register is
//  empty or being drained.
//
module min_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_word_t out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = mts_pkg::DATA_W;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // entries below the top; the top entry lives in registers
  logic signed [DW-1:0] value_mem [STACK_DEPTH];
  logic signed [DW-1:0] min_mem   [STACK_DEPTH];

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic signed [DW-1:0] top_val_r;
  logic signed [DW-1:0] top_min_r;
  logic signed [DW-1:0] rd_val_r;
  logic signed [DW-1:0] rd_min_r;
  logic                 out_valid_r;
  mts_pkg::out_word_t   out_data_r;

  logic                 in_fire;
  logic                 is_push;
  logic                 is_full;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_m2;
  logic [CW-1:0]        count_nxt;
  logic                 mem_we;
  logic                 mem_re;
  logic signed [DW-1:0] push_min;
  logic                 go_read;
  mts_pkg::out_word_t   out_nxt;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign is_push   = (in_data.kind == mts_pkg::KIND_PUSH);
  assign is_full   = (count_r == CW'(STACK_DEPTH));
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // running minimum of the new entry and everything below it
  assign push_min = ((count_r != '0) && (top_min_r < in_data.push_value)) ?
                    top_min_r : in_data.push_value;

  // spill the old top on push, fetch the next top on a deep pop
  assign mem_we  = in_fire && is_push && !is_full && (count_r != '0);
  assign go_read = in_fire && !is_push && (count_r > CW'(1));
  assign mem_re  = go_read;

  // result and next count for a word handled in its accept cycle
  always_comb begin
    count_nxt               = count_r;
    out_nxt.top_value       = '0;
    out_nxt.min_value       = '0;
    out_nxt.error_code      = mts_pkg::ERR_OK;
    if (is_push) begin
      if (is_full) begin
        out_nxt.error_code = mts_pkg::ERR_PUSH_FULL;
        out_nxt.top_value  = top_val_r;
        out_nxt.min_value  = top_min_r;
      end else begin
        count_nxt         = count_r + CW'(1);
        out_nxt.top_value = in_data.push_value;
        out_nxt.min_value = push_min;
      end
    end else begin
      if (count_r == '0) begin
        out_nxt.error_code = mts_pkg::ERR_POP_EMPTY;
      end else begin
        count_nxt = cnt_m1;
      end
    end
    out_nxt.entry_count = mts_pkg::COUNT_W'(count_nxt);
    out_nxt.is_empty    = (count_nxt == '0);
  end

  // entry stores
  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[cnt_m1[AW-1:0]] <= top_val_r;
      min_mem[cnt_m1[AW-1:0]]   <= top_min_r;
    end
    if (mem_re) begin
      rd_val_r <= value_mem[cnt_m2[AW-1:0]];
      rd_min_r <= min_mem[cnt_m2[AW-1:0]];
    end
  end

  // control, top entry and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            count_r <= count_nxt;
            if (is_push && !is_full) begin
              top_val_r <= in_data.push_value;
              top_min_r <= push_min;
            end
            if (go_read) begin
              state_r     <= ST_READ;
              out_valid_r <= 1'b0;
            end else begin
              out_valid_r <= 1'b1;
              out_data_r  <= out_nxt;
            end
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_READ: begin
          top_val_r              <= rd_val_r;
          top_min_r              <= rd_min_r;
          out_valid_r            <= 1'b1;
          out_data_r.top_value   <= rd_val_r;
          out_data_r.min_value   <= rd_min_r;
          out_data_r.entry_count <= mts_pkg::COUNT_W'(count_r);
          out_data_r.is_empty    <= 1'b0;
          out_data_r.error_code  <= mts_pkg::ERR_OK;
          state_r                <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // result register is always free while a fetch is in flight
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("result register busy during stack fetch");

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("entry count beyond depth");

  // an accepted push on a non-full stack grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_push && !is_full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the stack");

  // a fetch is followed by a result in the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("stack fetch gave no result");
`endif

endmodule

### verif/min_tracking_stack_check.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_check
// Watches both channels of the min tracking stack. Every accepted operation
// word updates a private copy of the stack, with a running minimum per entry,
// and queues the result word it must produce. Every accepted result word is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_check #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mts_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mts_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 words_checked,
  output int                 push_full_seen,
  output int                 pop_empty_seen,
  output int                 peak_level
);

  // private copy of the stack
  logic signed [mts_pkg::DATA_W-1:0] value_mem [STACK_DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] floor_mem [STACK_DEPTH];
  int level;

  mts_pkg::out_word_t expected_words[$];
  int fails, checked, full_hits, empty_hits, deepest;

  initial begin
    level      = 0;
    fails      = 0;
    checked    = 0;
    full_hits  = 0;
    empty_hits = 0;
    deepest    = 0;
  end

  // apply one operation to the private stack and return the word it yields
  function automatic mts_pkg::out_word_t apply_op(mts_pkg::in_word_t op);
    mts_pkg::out_word_t res;
    logic signed [mts_pkg::DATA_W-1:0] run_min;
    res = '0;
    res.error_code = mts_pkg::ERR_OK;
    if (op.kind == mts_pkg::KIND_PUSH) begin
      if (level >= STACK_DEPTH) begin
        res.error_code = mts_pkg::ERR_PUSH_FULL;
      end else begin
        run_min = op.push_value;
        if (level > 0 && floor_mem[level-1] < op.push_value)
          run_min = floor_mem[level-1];
        value_mem[level] = op.push_value;
        floor_mem[level] = run_min;
        level++;
      end
    end else if (level == 0) begin
      res.error_code = mts_pkg::ERR_POP_EMPTY;
    end else begin
      level--;
    end
    if (level > 0) begin
      res.top_value = value_mem[level-1];
      res.min_value = floor_mem[level-1];
    end
    res.entry_count = mts_pkg::COUNT_W'(level);
    res.is_empty    = (level == 0);
    return res;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // compare outgoing words first: a word leaving now stems from an earlier operation
  always @(posedge clk) begin
    mts_pkg::out_word_t want;
    if (!rst_n) begin
      level = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: result word with nothing expected, expected none, %s",
                   $time, "got");
          $display("  top %0d min %0d count %0d",
                   out_data.top_value, out_data.min_value, out_data.entry_count);
        end else begin
          want = expected_words.pop_front();
          check_field("top_value", want.top_value, out_data.top_value);
          check_field("min_value", want.min_value, out_data.min_value);
          check_field("entry_count", want.entry_count, out_data.entry_count);
          check_field("is_empty", want.is_empty, out_data.is_empty);
          check_field("error_code", want.error_code, out_data.error_code);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = apply_op(in_data);
        expected_words.push_back(want);
        if (want.error_code == mts_pkg::ERR_PUSH_FULL) full_hits++;
        if (want.error_code == mts_pkg::ERR_POP_EMPTY) empty_hits++;
        if (level > deepest) deepest = level;
      end
    end
    // handed to the top after this edge, so it never races the read
    fail_count     <= fails;
    pending        <= expected_words.size();
    words_checked  <= checked;
    push_full_seen <= full_hits;
    pop_empty_seen <= empty_hits;
    peak_level     <= deepest;
  end

endmodule

### verif/min_tracking_stack_test.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// Drives the min tracking stack with a short directed sequence (extreme
// values, equal values, popping the minimum, pops on an empty stack) and then
// random walks: near empty, a climb to a full stack, and hovering at full.
// Both channels idle at random; the checker beside the block does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_test;

  localparam int DEPTH        = mts_pkg::STACK_DEPTH_DEFAULT;
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  mts_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mts_pkg::out_word_t out_data;

  int fail_count, pending, words_checked, push_full_seen, pop_empty_seen, peak_level;
  int fill_level = 0;  // stack level as the stimulus sees it
  int in_calm    = 0;
  int out_calm   = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  min_tracking_stack #(.STACK_DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  min_tracking_stack_check #(.STACK_DEPTH(DEPTH)) i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .push_full_seen (push_full_seen),
    .pop_empty_seen (pop_empty_seen),
    .peak_level     (peak_level)
  );

  // idle length: mostly none, some short, a few long, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // full range, small values that repeat often, and the extremes
  function automatic logic signed [mts_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7: return int'($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(logic kind, logic signed [mts_pkg::DATA_W-1:0] value);
    mts_pkg::in_word_t w;
    int gap;
    w.kind       = kind;
    w.push_value = value;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (kind == mts_pkg::KIND_PUSH) begin
      if (fill_level < DEPTH) fill_level++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  // push with chance push_weight out of 16, else pop with junk in the value
  task automatic random_op(int push_weight);
    if ($urandom_range(0, 15) < push_weight) send_word(mts_pkg::KIND_PUSH, rand_value());
    else send_word(mts_pkg::KIND_POP, $urandom);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(out_calm);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, then extremes, with the minimum popped off the top
    send_word(mts_pkg::KIND_POP, 32'sh1234_5678);
    send_word(mts_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
    send_word(mts_pkg::KIND_PUSH, 32'sh8000_0000);
    send_word(mts_pkg::KIND_PUSH, 0);
    send_word(mts_pkg::KIND_PUSH, -1);
    send_word(mts_pkg::KIND_POP, 0);
    send_word(mts_pkg::KIND_POP, -1);
    send_word(mts_pkg::KIND_POP, 32'sh8000_0000);
    // equal values held at the minimum
    send_word(mts_pkg::KIND_PUSH, 5);
    send_word(mts_pkg::KIND_PUSH, 5);
    send_word(mts_pkg::KIND_PUSH, 3);
    send_word(mts_pkg::KIND_PUSH, 3);
    send_word(mts_pkg::KIND_PUSH, 7);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    // drain back to a single entry and then empty, then pop on empty again
    send_word(mts_pkg::KIND_PUSH, -1);
    send_word(mts_pkg::KIND_PUSH, 1);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, $urandom);
    send_word(mts_pkg::KIND_POP, 32'shFFFF_FFFF);

    // walk around the empty stack
    repeat (40) random_op(8);
    // climb to a full stack with a few pops along the way
    while (fill_level < DEPTH) random_op(15);
    // hover at full
    repeat (24) random_op(8);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d result words, deepest fill %0d of %0d entries",
             words_checked, peak_level, DEPTH);
    $display("pops on an empty stack: %0d, pushes on a full stack: %0d",
             pop_empty_seen, push_full_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #RUN_LIMIT_NS;
    $display("TEST FAILED");
    $finish;
  end

endmodule
